// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the queue checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define QMI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, on the checker's own clock and reset.
`define QMI_ASSERT_LOCAL(lbl, prop, msg) \
    `QMI_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ===== hw/rtl/qmi_pkg.sv =====
package qmi_pkg;

    localparam int QUEUE_DEPTH_DEF = 1024;
    localparam int ID_BITS_DEF     = 16;

    typedef enum logic [1:0] {
        FN_PUSH   = 2'd0,
        FN_INSERT = 2'd1,
        FN_POP    = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_POP  = 2'd1,
        CELL_INS  = 2'd2
    } t_cell_op;

endpackage

// ===== hw/rtl/qmi_cell.sv =====
module qmi_cell #(
    parameter int ID_BITS = qmi_pkg::ID_BITS_DEF,
    parameter int POS_W   = 11,
    parameter int INDEX   = 0
) (
    input  logic                 i_clk,
    input  qmi_pkg::t_cell_op    i_op,
    input  logic [POS_W-1:0]     i_pos,
    input  logic [ID_BITS-1:0]   i_id,
    input  logic [ID_BITS-1:0]   i_left,
    input  logic [ID_BITS-1:0]   i_right,
    output logic [ID_BITS-1:0]   o_val
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

    logic [ID_BITS-1:0] r_val;
    logic [ID_BITS-1:0] n_val;

    always_comb begin
        n_val = r_val;
        case (i_op)
            qmi_pkg::CELL_POP: begin
                n_val = i_right;
            end
            qmi_pkg::CELL_INS: begin
                if (MY_POS == i_pos) begin
                    n_val = i_id;
                end else if (MY_POS > i_pos) begin
                    n_val = i_left;
                end
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

// ===== hw/rtl/qmi_ctrl.sv =====
module qmi_ctrl #(
    parameter int QUEUE_DEPTH = qmi_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = qmi_pkg::ID_BITS_DEF,
    localparam int HALF_DEPTH = (QUEUE_DEPTH + 1) / 2,
    localparam int CNT_W      = $clog2(HALF_DEPTH + 1),
    localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [1:0]           i_func,
    output logic                 o_ready,
    input  logic [ID_BITS-1:0]   i_head_id,
    output qmi_pkg::t_cell_op    o_op,
    output logic [FILL_W-1:0]    o_pos,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [ID_BITS-1:0]   o_popped_id,
    output qmi_pkg::t_status     o_status,
    output logic [FILL_W-1:0]    o_fill
);

    logic [CNT_W-1:0]   r_front_cnt;
    logic [CNT_W-1:0]   n_front_cnt;
    logic [CNT_W-1:0]   r_back_cnt;
    logic [CNT_W-1:0]   n_back_cnt;
    logic               r_out_valid;
    logic [ID_BITS-1:0] r_popped_id;
    qmi_pkg::t_status   r_status;
    logic [FILL_W-1:0]  r_fill;

    logic               w_accept;
    logic [FILL_W-1:0]  w_total;
    logic [ID_BITS-1:0] w_popped;
    qmi_pkg::t_status   w_status;
    logic [FILL_W-1:0]  w_fill;

    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_total  = FILL_W'(r_front_cnt) + FILL_W'(r_back_cnt);

    always_comb begin
        n_front_cnt = r_front_cnt;
        n_back_cnt  = r_back_cnt;
        o_op        = qmi_pkg::CELL_HOLD;
        o_pos       = w_total;
        w_status    = qmi_pkg::ST_PUSHED;
        w_popped    = '0;
        if (w_accept) begin
            case (qmi_pkg::t_func'(i_func))
                qmi_pkg::FN_POP: begin
                    if (r_front_cnt == '0) begin
                        w_status = qmi_pkg::ST_EMPTY;
                    end else begin
                        w_status    = qmi_pkg::ST_POPPED;
                        w_popped    = i_head_id;
                        o_op        = qmi_pkg::CELL_POP;
                        n_front_cnt = r_front_cnt - 1'b1;
                    end
                end
                default: begin
                    if (w_total >= FILL_W'(QUEUE_DEPTH) ||
                        r_back_cnt >= CNT_W'(HALF_DEPTH)) begin
                        w_status = qmi_pkg::ST_FULL;
                    end else begin
                        o_op       = qmi_pkg::CELL_INS;
                        o_pos      = (i_func == qmi_pkg::FN_PUSH) ? w_total
                                                                  : FILL_W'(r_front_cnt);
                        n_back_cnt = r_back_cnt + 1'b1;
                    end
                end
            endcase
            // rebalance: back head becomes front tail, order unchanged
            if (n_front_cnt < n_back_cnt && n_front_cnt < CNT_W'(HALF_DEPTH)) begin
                n_front_cnt = n_front_cnt + 1'b1;
                n_back_cnt  = n_back_cnt - 1'b1;
            end
        end
    end

    assign w_fill = FILL_W'(n_front_cnt) + FILL_W'(n_back_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_cnt <= '0;
            r_back_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_front_cnt <= n_front_cnt;
            r_back_cnt  <= n_back_cnt;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_popped_id <= w_popped;
            r_status    <= w_status;
            r_fill      <= w_fill;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_popped_id = r_popped_id;
    assign o_status    = r_status;
    assign o_fill      = r_fill;

endmodule

// ===== hw/rtl/queue_with_middle_insert.sv =====
// A result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken; the whole cell row
// shifts or inserts in the accepting cycle, the next item may follow at once.
// Reset: synchronous, active low; clears the half counts and the result valid.
// Cell contents are not reset and need no clearing pass.
module queue_with_middle_insert #(
    parameter int QUEUE_DEPTH = qmi_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = qmi_pkg::ID_BITS_DEF,
    localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1),
    localparam int IN_DW      = ((ID_BITS + 7) / 8) * 8,
    localparam int OUT_DW     = ((ID_BITS + FILL_W + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [IN_DW-1:0]  i_s_tdata,   // entry_id
    input  logic [1:0]        i_s_tuser,   // func
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_DW-1:0] o_m_tdata,   // popped_id, fill_count
    output logic [1:0]        o_m_tuser    // status
);

    logic [ID_BITS-1:0] w_val [QUEUE_DEPTH];
    logic [ID_BITS-1:0] w_id;
    qmi_pkg::t_cell_op  w_op;
    logic [FILL_W-1:0]  w_pos;
    logic [ID_BITS-1:0] w_popped_id;
    qmi_pkg::t_status   w_status;
    logic [FILL_W-1:0]  w_fill;

    assign w_id = i_s_tdata[ID_BITS-1:0];

    qmi_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .i_func      (i_s_tuser),
        .o_ready     (o_s_tready),
        .i_head_id   (w_val[0]),
        .o_op        (w_op),
        .o_pos       (w_pos),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_popped_id (w_popped_id),
        .o_status    (w_status),
        .o_fill      (w_fill)
    );

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic [ID_BITS-1:0] w_left;
        logic [ID_BITS-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_id;
        end else begin : g_mid_l
            assign w_left = w_val[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_val[g+1];
        end

        qmi_cell #(
            .ID_BITS (ID_BITS),
            .POS_W   (FILL_W),
            .INDEX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_pos   (w_pos),
            .i_id    (w_id),
            .i_left  (w_left),
            .i_right (w_right),
            .o_val   (w_val[g])
        );
    end

    assign o_m_tdata = OUT_DW'({w_fill, w_popped_id});
    assign o_m_tuser = w_status;

endmodule

// ===== hw/rtl/qmi_checker.sv =====
`include "assert_macros.svh"

module qmi_checker #(
    parameter int QUEUE_DEPTH = qmi_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = qmi_pkg::ID_BITS_DEF,
    localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1),
    localparam int OUT_DW     = ((ID_BITS + FILL_W + 7) / 8) * 8
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_tvalid,
    input logic              o_s_tready,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [OUT_DW-1:0] o_m_tdata,
    input logic [1:0]        o_m_tuser
);

    logic               w_in_acc;
    logic               w_stall;
    logic               w_is_empty;
    logic               w_is_full;
    logic               w_no_entry;
    logic               w_at_depth;
    logic [OUT_DW+1:0]  w_out;
    logic [ID_BITS-1:0] w_popped;
    logic [FILL_W-1:0]  w_fill;

    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_stall    = o_m_tvalid && !i_m_tready;
    assign w_out      = {o_m_tuser, o_m_tdata};
    assign w_popped   = o_m_tdata[ID_BITS-1:0];
    assign w_fill     = o_m_tdata[ID_BITS+FILL_W-1:ID_BITS];
    assign w_is_empty = o_m_tvalid && (o_m_tuser == qmi_pkg::ST_EMPTY);
    assign w_is_full  = o_m_tvalid && (o_m_tuser == qmi_pkg::ST_FULL);
    assign w_no_entry = (w_fill == '0) && (w_popped == '0);
    assign w_at_depth = (w_fill == FILL_W'(QUEUE_DEPTH));

    `QMI_ASSERT_LOCAL(a_result_follows, w_in_acc |=> o_m_tvalid, "no result after item")
    `QMI_ASSERT_LOCAL(a_no_phantom, $rose(o_m_tvalid) |-> $past(w_in_acc), "result without item")
    `QMI_ASSERT_LOCAL(a_hold, w_stall |=> o_m_tvalid && $stable(w_out), "stalled result changed")
    `QMI_ASSERT_LOCAL(a_empty, w_is_empty |-> w_no_entry, "empty pop with entries")
    `QMI_ASSERT_LOCAL(a_full, w_is_full |-> w_at_depth, "full reject below depth")

endmodule

bind queue_with_middle_insert qmi_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
) u_qmi_checker (.*);
